### rtl/core/hrd_pkg.sv
`default_nettype none
package hrd_pkg;

  // Field widths
  localparam int HRD_SAMPLE_W  = 12;
  localparam int HRD_TIME_W    = 32;
  localparam int HRD_MV_W      = 13;
  localparam int HRD_BPM_W     = 8;
  localparam int HRD_CFG_W     = 16;
  localparam int HRD_CFG_IDX_W = 3;

  // Baseline filter, Q12.20
  localparam int HRD_FRAC_W = 20;
  localparam int HRD_BASE_W = 32;
  localparam int HRD_DIFF_W = 33;
  localparam int HRD_PROD_W = 45;
  localparam logic signed [11:0] HRD_ALPHA_NUM = 12'sd1049;
  localparam logic [HRD_BASE_W-1:0] HRD_BASE_RST = HRD_BASE_W'(2000 * (2 ** HRD_FRAC_W));

  // Millivolt scaling: mv = |ac| * 3300 / (4095 * 2^20)
  localparam int HRD_SCALE_W = 44;
  localparam int HRD_UQ_W    = 24;
  localparam int HRD_RPROD_W = 49;
  localparam int HRD_MAG_Q_W = 12;
  localparam logic [11:0] HRD_MV_SCALE = 12'd3300;
  localparam logic [HRD_UQ_W-1:0] HRD_FULL_SCALE = 24'd4095;
  localparam int HRD_RECIP_SH = 36;
  localparam logic [24:0] HRD_RECIP_FS = 25'd16781313;  // floor(2^36 / 4095)

  // Interval divider
  localparam int HRD_DIV_W     = 16;
  localparam int HRD_DIV_CNT_W = $clog2(HRD_DIV_W + 1);
  localparam logic [HRD_DIV_W-1:0] HRD_BPM_NUM = 16'd60000;

  // Rate history ring
  localparam int HRD_HIST_DEPTH  = 12;
  localparam int HRD_IDX_W       = (HRD_HIST_DEPTH > 1) ? $clog2(HRD_HIST_DEPTH) : 1;
  localparam int HRD_SUM_MAX     = HRD_HIST_DEPTH * 255;
  localparam int HRD_SUM_W       = $clog2(HRD_SUM_MAX + 1);
  localparam int HRD_AVG_K       = HRD_SUM_W;
  localparam int HRD_AVG_RECIP_W = HRD_AVG_K + 1;
  localparam logic [HRD_AVG_RECIP_W-1:0] HRD_AVG_RECIP =
    HRD_AVG_RECIP_W'((2 ** HRD_AVG_K) / HRD_HIST_DEPTH);
  localparam int HRD_AVG_PROD_W  = HRD_SUM_W + HRD_AVG_RECIP_W;
  localparam logic [HRD_BPM_W-1:0] HRD_LAST_BPM_RST = 8'd70;

  // Task queue between front and back
  localparam int HRD_TQ_DEPTH = 2;
  localparam int HRD_TQ_PTR_W = $clog2(HRD_TQ_DEPTH);
  localparam int HRD_TQ_CNT_W = $clog2(HRD_TQ_DEPTH + 1);

  // Register reset values
  localparam logic [11:0] HRD_THR_RST     = 12'd1000;
  localparam logic [15:0] HRD_REFR_RST    = 16'd300;
  localparam logic [15:0] HRD_MIN_INT_RST = 16'd300;
  localparam logic [15:0] HRD_MAX_INT_RST = 16'd2000;
  localparam logic [7:0]  HRD_JUMP_RST    = 8'd30;

  typedef enum logic [HRD_CFG_IDX_W-1:0] {
    CFG_BEAT_THRESHOLD  = 3'd0,
    CFG_REFRACTORY_MS   = 3'd1,
    CFG_MIN_INTERVAL_MS = 3'd2,
    CFG_MAX_INTERVAL_MS = 3'd3,
    CFG_MAX_BPM_JUMP    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0] beat_threshold;
    logic [15:0] refractory_ms;
    logic [15:0] min_interval_ms;
    logic [15:0] max_interval_ms;
    logic [7:0]  max_bpm_jump;
  } cfg_t;

  typedef struct packed {
    logic                       conn;
    logic                       bpm_go;
    logic [HRD_DIV_W-1:0]       interval;
    logic signed [HRD_MV_W-1:0] mv;
  } task_t;

  typedef enum logic [3:0] {
    F_IDLE, F_DIFF, F_MULB, F_BASE, F_AC, F_BEAT, F_SCALE, F_RECIP, F_FIX, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_DIV, B_RING, B_AVG, B_FIX, B_OUT
  } back_state_t;

endpackage
`default_nettype wire

### rtl/core/hrd_div.sv
`default_nettype none
module hrd_div import hrd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [HRD_DIV_W-1:0] divisor,
  output logic                 done,
  output logic [HRD_DIV_W-1:0] quotient
);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [HRD_DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [HRD_DIV_W-1:0]     rem_r, rem_nxt;
  logic [HRD_DIV_W-1:0]     quo_r, quo_nxt;
  logic [HRD_DIV_W-1:0]     dvs_r;
  logic [HRD_DIV_W:0]       shifted;
  logic [HRD_DIV_W+1:0]     trial;

  // Restoring division of a fixed dividend, one quotient bit a cycle
  always_comb begin
    shifted  = {rem_r, quo_r[HRD_DIV_W-1]};
    trial    = {1'b0, shifted} - (HRD_DIV_W+2)'(dvs_r);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = HRD_DIV_CNT_W'(HRD_DIV_W);
      rem_nxt  = '0;
      quo_nxt  = HRD_BPM_NUM;
    end else if (busy_r) begin
      if (trial[HRD_DIV_W+1]) begin
        rem_nxt = shifted[HRD_DIV_W-1:0];
        quo_nxt = {quo_r[HRD_DIV_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[HRD_DIV_W-1:0];
        quo_nxt = {quo_r[HRD_DIV_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == HRD_DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

### rtl/core/hrd_front.sv
`default_nettype none
module hrd_front import hrd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [HRD_SAMPLE_W-1:0] in_sample,
  input  logic                    in_lead_off_pos,
  input  logic                    in_lead_off_neg,
  input  logic [HRD_TIME_W-1:0]   in_time_ms,
  output logic                    tq_push,
  input  logic                    tq_full,
  output task_t                   tq_task
);

  front_state_t state_r, state_nxt;

  logic [HRD_SAMPLE_W-1:0]      sample_r;
  logic                         conn_r;
  logic [HRD_TIME_W-1:0]        time_r;
  logic [HRD_BASE_W-1:0]        baseline_r, baseline_nxt;
  logic [HRD_TIME_W-1:0]        last_beat_r;
  logic signed [HRD_DIFF_W-1:0] diff_r;
  logic [HRD_TIME_W-1:0]        elapsed_r, elapsed_nxt;
  logic signed [HRD_PROD_W-1:0] prod_r, prod_nxt;
  logic signed [HRD_DIFF_W-1:0] ac_r;
  logic [HRD_BASE_W-1:0]        mag_r;
  logic                         neg_r;
  logic                         go_r;
  logic [HRD_DIV_W-1:0]         interval_r;
  logic [HRD_UQ_W-1:0]          u_r, u_nxt;
  logic [HRD_MAG_Q_W-1:0]       q0_r, q0_nxt;
  logic [HRD_MAG_Q_W-1:0]       q_r, q_nxt;

  logic [HRD_BASE_W-1:0]        x_w;
  logic signed [HRD_DIFF_W-1:0] sub_w;
  logic signed [HRD_PROD_W-1:0] step_w;
  logic [HRD_BASE_W+1:0]        base_sum_w;
  logic signed [HRD_DIFF_W-1:0] thr_w;
  logic                         beat_w;
  logic                         range_w;
  logic [HRD_DIFF_W-1:0]        mag_w;
  logic [HRD_SCALE_W-1:0]       tprod_w;
  logic [HRD_RPROD_W-1:0]       rprod_w;
  logic [HRD_UQ_W-1:0]          back_w;
  logic [HRD_UQ_W-1:0]          rem_w;
  logic signed [HRD_MV_W-1:0]   mv_w;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (in_push) begin
        state_nxt = F_DIFF;
      end
      F_DIFF:  state_nxt = F_MULB;
      F_MULB:  state_nxt = F_BASE;
      F_BASE:  state_nxt = F_AC;
      F_AC:    state_nxt = F_BEAT;
      F_BEAT:  state_nxt = F_SCALE;
      F_SCALE: state_nxt = F_RECIP;
      F_RECIP: state_nxt = F_FIX;
      F_FIX:   state_nxt = F_PUSH;
      F_PUSH:  if (!tq_full) begin
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_full = (state_r != F_IDLE);
    tq_push = (state_r == F_PUSH) && !tq_full;
  end

  // Datapath
  always_comb begin
    x_w          = {sample_r, HRD_FRAC_W'(0)};
    sub_w        = $signed({1'b0, x_w}) - $signed({1'b0, baseline_r});
    elapsed_nxt  = time_r - last_beat_r;
    prod_nxt     = $signed(HRD_PROD_W'(diff_r)) * $signed(HRD_PROD_W'(HRD_ALPHA_NUM));
    step_w       = prod_r >>> HRD_FRAC_W;
    base_sum_w   = {2'b00, baseline_r} + step_w[HRD_BASE_W+1:0];
    baseline_nxt = base_sum_w[HRD_BASE_W-1:0];
    thr_w        = $signed({1'b0, cfg.beat_threshold, HRD_FRAC_W'(0)});
    beat_w       = conn_r && (ac_r > thr_w) &&
                   (elapsed_r > HRD_TIME_W'(cfg.refractory_ms));
    range_w      = (elapsed_r > HRD_TIME_W'(cfg.min_interval_ms)) &&
                   (elapsed_r < HRD_TIME_W'(cfg.max_interval_ms));
    mag_w        = ac_r[HRD_DIFF_W-1] ? HRD_DIFF_W'(-ac_r) : HRD_DIFF_W'(ac_r);
    tprod_w      = HRD_SCALE_W'(mag_r) * HRD_SCALE_W'(HRD_MV_SCALE);
    u_nxt        = tprod_w[HRD_SCALE_W-1:HRD_FRAC_W];
    rprod_w      = HRD_RPROD_W'(u_r) * HRD_RPROD_W'(HRD_RECIP_FS);
    q0_nxt       = rprod_w[HRD_RECIP_SH +: HRD_MAG_Q_W];
    // the reciprocal estimate is at most one short
    back_w       = (HRD_UQ_W'(q0_r) << HRD_SAMPLE_W) - HRD_UQ_W'(q0_r);
    rem_w        = u_r - back_w;
    q_nxt        = (rem_w >= HRD_FULL_SCALE) ? q0_r + 1'b1 : q0_r;
    if (!conn_r) begin
      mv_w = '0;
    end else if (neg_r) begin
      mv_w = -$signed({1'b0, q_r});
    end else begin
      mv_w = $signed({1'b0, q_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      baseline_r  <= HRD_BASE_RST;
      last_beat_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_BASE && conn_r) begin
        baseline_r <= baseline_nxt;
      end
      if (state_r == F_BEAT && beat_w) begin
        last_beat_r <= time_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: if (in_push) begin
        sample_r <= in_sample;
        conn_r   <= !(in_lead_off_pos && in_lead_off_neg);
        time_r   <= in_time_ms;
      end
      F_DIFF: begin
        diff_r    <= sub_w;
        elapsed_r <= elapsed_nxt;
      end
      F_MULB:  prod_r <= prod_nxt;
      F_AC:    ac_r <= sub_w;
      F_BEAT: begin
        go_r       <= beat_w && range_w;
        interval_r <= elapsed_r[HRD_DIV_W-1:0];
        mag_r      <= mag_w[HRD_BASE_W-1:0];
        neg_r      <= ac_r[HRD_DIFF_W-1];
      end
      F_SCALE: u_r  <= u_nxt;
      F_RECIP: q0_r <= q0_nxt;
      F_FIX:   q_r  <= q_nxt;
      default: ;
    endcase
  end

  always_comb begin
    tq_task.conn     = conn_r;
    tq_task.bpm_go   = go_r;
    tq_task.interval = interval_r;
    tq_task.mv       = mv_w;
  end

endmodule
`default_nettype wire

### rtl/core/hrd_task_q.sv
`default_nettype none
module hrd_task_q import hrd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  task_t wr_task,
  output logic  full,
  input  logic  pop,
  output task_t rd_task,
  output logic  empty
);

  task_t                   mem_r [HRD_TQ_DEPTH];
  logic [HRD_TQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [HRD_TQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [HRD_TQ_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == HRD_TQ_PTR_W'(HRD_TQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == HRD_TQ_PTR_W'(HRD_TQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_task;
    end
  end

  assign rd_task = mem_r[rd_ptr_r];
  assign full    = (cnt_r == HRD_TQ_CNT_W'(HRD_TQ_DEPTH));
  assign empty   = (cnt_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("task word pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("task word popped from empty queue");

endmodule
`default_nettype wire

### rtl/core/hrd_back.sv
`default_nettype none
module hrd_back import hrd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [HRD_BPM_W-1:0]       max_bpm_jump,
  input  logic                       tq_empty,
  output logic                       tq_pop,
  input  task_t                      tq_task,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [HRD_MV_W-1:0] out_ecg_millivolts,
  output logic [HRD_BPM_W-1:0]       out_heart_rate,
  output logic                       out_leads_connected
);

  back_state_t state_r, state_nxt;

  task_t                 cur_r;
  logic [HRD_BPM_W-1:0]  hist_r [HRD_HIST_DEPTH];
  logic [HRD_IDX_W-1:0]  idx_r, idx_nxt;
  logic [HRD_SUM_W-1:0]  sum_r, sum_nxt;
  logic [HRD_BPM_W-1:0]  last_bpm_r;
  logic [HRD_BPM_W-1:0]  avg_r, avg_nxt;
  logic [HRD_BPM_W-1:0]  bpm_r, bpm_nxt;
  logic [HRD_BPM_W-1:0]  q0_r, q0_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [HRD_MV_W-1:0] out_mv_r;
  logic [HRD_BPM_W-1:0]  out_hr_r;
  logic                  out_conn_r;

  logic                  div_start;
  logic                  div_done;
  logic [HRD_DIV_W-1:0]  div_quo;
  logic                  ring_clr;
  logic                  out_free;
  logic                  out_wr;
  logic [HRD_BPM_W-1:0]  jump_w;
  logic                  jump_ok;
  logic [HRD_AVG_PROD_W-1:0] avg_prod_w;
  logic [HRD_SUM_W-1:0]  avg_back_w;
  logic [HRD_SUM_W-1:0]  avg_rem_w;

  hrd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (tq_task.interval),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_free = !out_valid_r || out_pop;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (!tq_empty) begin
        if (tq_task.conn && tq_task.bpm_go) begin
          state_nxt = B_DIV;
        end else begin
          state_nxt = B_OUT;
        end
      end
      B_DIV:  if (div_done) begin
        state_nxt = B_RING;
      end
      B_RING: state_nxt = B_AVG;
      B_AVG:  state_nxt = B_FIX;
      B_FIX:  state_nxt = B_OUT;
      B_OUT:  if (out_free) begin
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    tq_pop    = (state_r == B_IDLE) && !tq_empty;
    div_start = tq_pop && tq_task.conn && tq_task.bpm_go;
    ring_clr  = tq_pop && !tq_task.conn;
    out_wr    = (state_r == B_OUT) && out_free;
  end

  // Ring and average arithmetic
  always_comb begin
    bpm_nxt    = (div_quo > HRD_DIV_W'(255)) ? '1 : div_quo[HRD_BPM_W-1:0];
    jump_w     = (bpm_r > last_bpm_r) ? bpm_r - last_bpm_r : last_bpm_r - bpm_r;
    jump_ok    = jump_w < max_bpm_jump;
    sum_nxt    = sum_r - HRD_SUM_W'(hist_r[idx_r]) + HRD_SUM_W'(bpm_r);
    idx_nxt    = (idx_r == HRD_IDX_W'(HRD_HIST_DEPTH - 1)) ? '0 : idx_r + 1'b1;
    avg_prod_w = HRD_AVG_PROD_W'(sum_r) * HRD_AVG_PROD_W'(HRD_AVG_RECIP);
    q0_nxt     = avg_prod_w[HRD_AVG_K +: HRD_BPM_W];
    // estimate is at most one short of the true quotient
    avg_back_w = HRD_SUM_W'(HRD_SUM_W'(q0_r) * HRD_SUM_W'(HRD_HIST_DEPTH));
    avg_rem_w  = sum_r - avg_back_w;
    avg_nxt    = (avg_rem_w >= HRD_SUM_W'(HRD_HIST_DEPTH)) ? q0_r + 1'b1 : q0_r;
    out_valid_nxt = out_wr || (out_valid_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      idx_r       <= '0;
      sum_r       <= '0;
      last_bpm_r  <= HRD_LAST_BPM_RST;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < HRD_HIST_DEPTH; k++) begin
        hist_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ring_clr) begin
        // leads off: drop the whole history
        sum_r <= '0;
        avg_r <= '0;
        for (int k = 0; k < HRD_HIST_DEPTH; k++) begin
          hist_r[k] <= '0;
        end
      end
      if (state_r == B_RING && jump_ok) begin
        hist_r[idx_r] <= bpm_r;
        sum_r         <= sum_nxt;
        idx_r         <= idx_nxt;
        last_bpm_r    <= bpm_r;
      end
      if (state_r == B_FIX) begin
        avg_r <= avg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tq_pop) begin
      cur_r <= tq_task;
    end
    if (state_r == B_DIV && div_done) begin
      bpm_r <= bpm_nxt;
    end
    if (state_r == B_AVG) begin
      q0_r <= q0_nxt;
    end
    if (out_wr) begin
      out_mv_r   <= cur_r.mv;
      out_hr_r   <= avg_r;
      out_conn_r <= cur_r.conn;
    end
  end

  assign out_empty           = !out_valid_r;
  assign out_ecg_millivolts  = out_mv_r;
  assign out_heart_rate      = out_hr_r;
  assign out_leads_connected = out_conn_r;

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= HRD_SUM_W'(HRD_SUM_MAX))
    else $error("history sum beyond ring capacity");

  a_lead_off_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ring_clr |=> (sum_r == '0) && (avg_r == '0))
    else $error("ring not cleared after leads off");

  a_out_written: assert property (@(posedge clk) disable iff (!rst_n)
    out_wr |=> !out_empty)
    else $error("result word lost at output register");

  a_div_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == B_DIV))
    else $error("divider finished outside its wait state");

endmodule
`default_nettype wire

### rtl/core/ecg_heart_rate_detector_top.sv
`default_nettype none
// ECG heart-rate detector.
// Input queue: drive in_sample, lead-off flags and in_time_ms with in_push;
// a word is taken when in_push is high and in_full is low.
// Result queue: the oldest result sits on out_* while out_empty is low and
// is taken when out_pop is high. One result word per input word, in order.
// Config: cfg_wr_en writes cfg_wdata to register cfg_index (0 threshold,
// 1 refractory, 2 min interval, 3 max interval, 4 max jump); other indexes
// are ignored. Write only while the block is idle.
// Front end: a sample runs through the diff, baseline multiply, baseline,
// ac, beat, scale, reciprocal, fix and push states (baseline filter,
// millivolt scaling); in_full stays high until its task word is pushed.
// A sample that yields a rate runs the 16-step interval divider and ring
// update in the back end; others go straight to the output register.
// A two-word task queue and the output register decouple the halves, so
// a stalled out_pop backs up into in_full only once both are full.
// Reset (synchronous, rst_n low) restores register defaults, the 2000-count
// baseline, an empty history and a last valid rate of 70.
module ecg_heart_rate_detector_top import hrd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [HRD_CFG_IDX_W-1:0]   cfg_index,
  input  logic [HRD_CFG_W-1:0]       cfg_wdata,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [HRD_SAMPLE_W-1:0]    in_sample,
  input  logic                       in_lead_off_pos,
  input  logic                       in_lead_off_neg,
  input  logic [HRD_TIME_W-1:0]      in_time_ms,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [HRD_MV_W-1:0] out_ecg_millivolts,
  output logic [HRD_BPM_W-1:0]       out_heart_rate,
  output logic                       out_leads_connected
);

  cfg_t  cfg_r, cfg_nxt;
  logic  tq_push;
  logic  tq_full;
  task_t tq_wr_task;
  logic  tq_pop;
  logic  tq_empty;
  task_t tq_rd_task;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BEAT_THRESHOLD:  cfg_nxt.beat_threshold  = cfg_wdata[11:0];
        CFG_REFRACTORY_MS:   cfg_nxt.refractory_ms   = cfg_wdata;
        CFG_MIN_INTERVAL_MS: cfg_nxt.min_interval_ms = cfg_wdata;
        CFG_MAX_INTERVAL_MS: cfg_nxt.max_interval_ms = cfg_wdata;
        CFG_MAX_BPM_JUMP:    cfg_nxt.max_bpm_jump    = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beat_threshold  <= HRD_THR_RST;
      cfg_r.refractory_ms   <= HRD_REFR_RST;
      cfg_r.min_interval_ms <= HRD_MIN_INT_RST;
      cfg_r.max_interval_ms <= HRD_MAX_INT_RST;
      cfg_r.max_bpm_jump    <= HRD_JUMP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hrd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_sample       (in_sample),
    .in_lead_off_pos (in_lead_off_pos),
    .in_lead_off_neg (in_lead_off_neg),
    .in_time_ms      (in_time_ms),
    .tq_push         (tq_push),
    .tq_full         (tq_full),
    .tq_task         (tq_wr_task)
  );

  hrd_task_q u_task_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (tq_push),
    .wr_task (tq_wr_task),
    .full    (tq_full),
    .pop     (tq_pop),
    .rd_task (tq_rd_task),
    .empty   (tq_empty)
  );

  hrd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .max_bpm_jump        (cfg_r.max_bpm_jump),
    .tq_empty            (tq_empty),
    .tq_pop              (tq_pop),
    .tq_task             (tq_rd_task),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_ecg_millivolts  (out_ecg_millivolts),
    .out_heart_rate      (out_heart_rate),
    .out_leads_connected (out_leads_connected)
  );

endmodule
`default_nettype wire
